FILE: rtl/lkl_pkg.sv
package lkl_pkg;

    localparam int KEY_W = 32;
    localparam int CAP_W = 5;
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic OP_ACCESS = 1'b0;
    localparam logic OP_DUMP   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DUMP
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic capture;     // latch key and hit vector on an access transfer
        logic update;      // apply move-to-front / insert
        logic dump_start;  // clear the dump position
        logic emit;        // load output with head entry, rotate list
        logic emit_empty;  // load output with the empty-list marker
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic list_empty;
        logic emit_last;
        logic out_free;
    } dp_status_t;

endpackage

FILE: rtl/lkl_ctrl.sv
module lkl_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_opcode,
    output logic                s_ready,
    input  lkl_pkg::dp_status_t status,
    output lkl_pkg::dp_cmd_t    cmd
);

    lkl_pkg::state_t state_reg;
    lkl_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= lkl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            lkl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_opcode == lkl_pkg::OP_ACCESS) ? lkl_pkg::ST_UPDATE
                                                                  : lkl_pkg::ST_DUMP;
                end
            end
            lkl_pkg::ST_UPDATE: begin
                state_next = lkl_pkg::ST_IDLE;
            end
            lkl_pkg::ST_DUMP: begin
                if (status.out_free && (status.list_empty || status.emit_last)) begin
                    state_next = lkl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkl_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            lkl_pkg::ST_IDLE: begin
                s_ready        = 1'b1;
                cmd.capture    = s_valid && (s_opcode == lkl_pkg::OP_ACCESS);
                cmd.dump_start = s_valid && (s_opcode == lkl_pkg::OP_DUMP);
            end
            lkl_pkg::ST_UPDATE: begin
                cmd.update = 1'b1;
            end
            lkl_pkg::ST_DUMP: begin
                cmd.emit       = status.out_free && !status.list_empty;
                cmd.emit_empty = status.out_free && status.list_empty;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

FILE: rtl/lkl_datapath.sv
module lkl_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [lkl_pkg::CAP_W-1:0]          cfg_wr_data,
    input  logic signed [lkl_pkg::KEY_W-1:0]   s_key,
    input  lkl_pkg::dp_cmd_t                   cmd,
    output lkl_pkg::dp_status_t                status,
    input  logic                               m_ready,
    output logic                               m_valid,
    output logic signed [lkl_pkg::KEY_W-1:0]   m_entry_key,
    output logic                               m_entry_valid,
    output logic                               m_last
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int EW = (CW > lkl_pkg::CAP_W) ? CW : lkl_pkg::CAP_W;

    // list storage: index 0 is newest; an update shifts entries back from the head,
    // a dump rotates the occupied part toward the head
    logic [lkl_pkg::KEY_W-1:0] keys_reg  [MAX_ENTRIES];
    logic [lkl_pkg::KEY_W-1:0] keys_next [MAX_ENTRIES];

    logic [CW-1:0]              count_reg, count_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic [lkl_pkg::CAP_W-1:0]  cap_reg;
    logic [lkl_pkg::KEY_W-1:0]  key_cap_reg;
    logic [MAX_ENTRIES-1:0]     hit_reg, hit_next;

    logic                       out_valid_reg, out_valid_next;
    logic [lkl_pkg::KEY_W-1:0]  out_key_reg, out_key_next;
    logic                       out_entry_valid_reg, out_entry_valid_next;
    logic                       out_last_reg, out_last_next;

    logic [EW-1:0]              eff_cap;
    logic [EW-1:0]              count_ext;
    logic [EW-1:0]              upto;
    logic                       any_hit;
    logic                       room;
    logic [CW-1:0]              count_m1;
    logic [MAX_ENTRIES-1:0]     shift_en;
    logic                       hit_seen;

    // clamp capacity to [1, MAX_ENTRIES]
    always_comb begin
        if (cap_reg == '0) begin
            eff_cap = EW'(1);
        end else if (EW'(cap_reg) > EW'(MAX_ENTRIES)) begin
            eff_cap = EW'(MAX_ENTRIES);
        end else begin
            eff_cap = EW'(cap_reg);
        end
    end

    assign count_ext = EW'(count_reg);
    assign count_m1  = count_reg - CW'(1);
    assign any_hit   = |hit_reg;
    assign room      = count_ext < eff_cap;

    // deepest slot touched by an insert on a miss
    always_comb begin
        if (room) begin
            upto = count_ext;
        end else begin
            upto = count_ext - EW'(1);
        end
        if (upto > EW'(MAX_ENTRIES - 1)) begin
            upto = EW'(MAX_ENTRIES - 1);
        end
    end

    // on a hit, slots up to the first match shift back; on a miss up to upto
    always_comb begin
        hit_seen    = 1'b0;
        shift_en    = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (i > 0) begin
                shift_en[i] = any_hit ? !hit_seen : (EW'(i) <= upto);
            end
            hit_seen = hit_seen | hit_reg[i];
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            hit_next[i] = (keys_reg[i] == s_key) && (CW'(i) < count_reg);
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            keys_next[i] = keys_reg[i];
        end
        count_next = count_reg;
        if (cmd.update) begin
            keys_next[0] = key_cap_reg;
            for (int i = 1; i < MAX_ENTRIES; i++) begin
                if (shift_en[i]) begin
                    keys_next[i] = keys_reg[i-1];
                end
            end
            if (!any_hit && room) begin
                count_next = count_reg + CW'(1);
            end
        end else if (cmd.emit) begin
            // rotate the occupied part by one so the next entry reaches the head
            for (int i = 0; i < MAX_ENTRIES; i++) begin
                if (CW'(i) == count_m1) begin
                    keys_next[i] = keys_reg[0];
                end else if ((CW'(i) < count_m1) && (i < MAX_ENTRIES - 1)) begin
                    keys_next[i] = keys_reg[(i < MAX_ENTRIES - 1) ? i + 1 : i];
                end
            end
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (cmd.dump_start) begin
            idx_next = '0;
        end else if (cmd.emit) begin
            idx_next = idx_reg + CW'(1);
        end
    end

    always_comb begin
        out_valid_next       = out_valid_reg && !m_ready;
        out_key_next         = out_key_reg;
        out_entry_valid_next = out_entry_valid_reg;
        out_last_next        = out_last_reg;
        if (cmd.emit) begin
            out_valid_next       = 1'b1;
            out_key_next         = keys_reg[0];
            out_entry_valid_next = 1'b1;
            out_last_next        = (idx_reg == count_m1);
        end else if (cmd.emit_empty) begin
            out_valid_next       = 1'b1;
            out_key_next         = '0;
            out_entry_valid_next = 1'b0;
            out_last_next        = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            idx_reg       <= '0;
            cap_reg       <= lkl_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            keys_reg[i] <= keys_next[i];
        end
        if (cmd.capture) begin
            key_cap_reg <= s_key;
            hit_reg     <= hit_next;
        end
        out_key_reg         <= out_key_next;
        out_entry_valid_reg <= out_entry_valid_next;
        out_last_reg        <= out_last_next;
    end

    assign status.list_empty = (count_reg == '0);
    assign status.emit_last  = (idx_reg == count_m1);
    assign status.out_free   = !out_valid_reg || m_ready;

    assign m_valid       = out_valid_reg;
    assign m_entry_key   = out_key_reg;
    assign m_entry_valid = out_entry_valid_reg;
    assign m_last        = out_last_reg;

endmodule

FILE: rtl/lru_key_list.sv
// LRU key list: holds up to MAX_ENTRIES 32-bit keys in recency order, with the
// live limit set by the 5-bit capacity register (0 acts as 1, values above
// MAX_ENTRIES act as MAX_ENTRIES; reset value 16). Opcode 0 accesses s_key: a
// hit moves it to the front, a miss inserts it at the front and drops the
// oldest key once the list is at capacity. Lowering capacity below the current
// count keeps the stored keys; later misses then replace the oldest key one
// for one. An access produces no output transfer: the transfer cycle compares
// the key against every entry in parallel and registers the hit vector, the
// next cycle shifts the list while the block is not ready for input.
// Opcode 1 dumps the list newest first, one output transfer per key with
// m_last on the final one; an empty list gives a single transfer with
// m_entry_valid low, m_entry_key zero and m_last high. In a dump, entries
// leave through the list head one per cycle while m_ready stays high, as the
// occupied part rotates.
// A new input transfer is taken once the previous item is finished, even
// while the last result still waits in the output register. Write capacity
// only while the block is idle.
module lru_key_list #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              cfg_wr_en,
    input  logic [lkl_pkg::CAP_W-1:0]         cfg_wr_data,

    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_opcode,
    input  logic signed [lkl_pkg::KEY_W-1:0]  s_key,

    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [lkl_pkg::KEY_W-1:0]  m_entry_key,
    output logic                              m_entry_valid,
    output logic                              m_last
);

    lkl_pkg::dp_cmd_t    cmd;
    lkl_pkg::dp_status_t status;

    // sequencing: idle / list update / dump
    lkl_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_opcode (s_opcode),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // key storage, parallel compare, count, capacity and output register
    lkl_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_key         (s_key),
        .cmd           (cmd),
        .status        (status),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_entry_key   (m_entry_key),
        .m_entry_valid (m_entry_valid),
        .m_last        (m_last)
    );

endmodule

FILE: rtl/lkl_checker.sv
module lkl_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input logic                              s_opcode,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [lkl_pkg::KEY_W-1:0]  m_entry_key,
    input logic                              m_entry_valid,
    input logic                              m_last
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_entry_key)
            && $stable(m_entry_valid) && $stable(m_last))
        else $error("output changed while stalled");

    // an empty-list marker is always the final result
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_entry_valid |-> m_last && (m_entry_key == '0))
        else $error("empty marker without last");

    // an access creates no output transfer
    a_access_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == lkl_pkg::OP_ACCESS) && !m_valid
            |=> !m_valid)
        else $error("access produced a result");

    // an access keeps the block busy while the list updates, then returns to ready
    a_access_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_opcode == lkl_pkg::OP_ACCESS)
            |=> !s_ready ##1 s_ready)
        else $error("access timing wrong");

endmodule

bind lru_key_list lkl_checker u_lkl_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_opcode      (s_opcode),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_entry_key   (m_entry_key),
    .m_entry_valid (m_entry_valid),
    .m_last        (m_last)
);
